// ===== hw/rtl/lottery_scheduler_ticket_table_top_macros.svh =====
// Assertion macros for the lottery scheduler ticket table.
// Each macro is clocked by aclk and disabled while aresetn is low.
`ifndef LOTTERY_SCHEDULER_TICKET_TABLE_TOP_MACROS_SVH
`define LOTTERY_SCHEDULER_TICKET_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lst_pkg.sv =====
// Shared constants, codes and control structs for the lottery scheduler.
// Used by lst_ctrl, lst_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package lst_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_TICKETS   = 1024;

    localparam int PROC_W    = $clog2(MAX_PROCESSES + 1);
    localparam int OWNER_W   = $clog2(MAX_PROCESSES);
    localparam int TICKET_W  = $clog2(MAX_TICKETS);
    localparam int COUNT_W   = $clog2(MAX_TICKETS + 1);
    localparam int RAND_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int DIV_CNT_W = $clog2(RAND_W);

    localparam int S_FIELDS_W = COUNT_W + PROC_W + RAND_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + TICKET_W + PROC_W + COUNT_W + PROC_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_ALL  = 2'd1,
        OP_ONE  = 2'd2,
        OP_DRAW = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_PROC_FULL   = 3'd1,
        ST_TICKET_FULL = 3'd2,
        ST_BAD_ID      = 3'd3,
        ST_NO_TICKETS  = 3'd4
    } status_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic grant_step;
        logic div_step;
        logic mem_read;
        logic out_load;
    } lst_cmd_t;

    typedef struct packed {
        op_t  op;
        logic eval_ok;
        logic zero_work;
        logic grant_last;
        logic div_last;
        logic out_free;
    } lst_stat_t;

endpackage

// ===== hw/rtl/lst_ctrl.sv =====
// Sequencing state machine for the lottery scheduler.
// Depends on lst_pkg; drives lst_dp through lst_cmd_t and reads lst_stat_t.
`timescale 1ns / 1ps

module lst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output lst_pkg::lst_cmd_t   cmd,
    input  lst_pkg::lst_stat_t  stat
);
    import lst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_GRANT = 6'b000100,
        S_DIV   = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                // Rejected requests, adds and empty grants finish at once.
                priority if (!stat.eval_ok || stat.op == OP_ADD || stat.zero_work) begin
                    state_next = S_DONE;
                end else if (stat.op == OP_DRAW) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT: begin
                cmd.grant_step = 1'b1;
                if (stat.grant_last) begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/lst_dp.sv =====
// Datapath of the lottery scheduler: request registers, counters, owner table,
// bit-serial modulo unit and result register. Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lst_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [lst_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lst_pkg::M_TDATA_W-1:0]  m_tdata,
    input  lst_pkg::lst_cmd_t              cmd,
    output lst_pkg::lst_stat_t             stat
);
    import lst_pkg::*;

    localparam int NEED_W = COUNT_W + PROC_W;

    // Owner table; entries are only read below the issued count.
    logic [OWNER_W-1:0]   ticket_owner_mem [MAX_TICKETS];

    op_t                  op_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [PROC_W-1:0]    pid_reg;
    logic [RAND_W-1:0]    rnd_reg;
    logic [COUNT_W-1:0]   issued_reg;
    logic [PROC_W-1:0]    num_reg;
    status_t              status_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [COUNT_W-1:0]   left_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] bit_reg;
    logic [OWNER_W-1:0]   owner_rd_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [COUNT_W-1:0]   room;
    logic [NEED_W-1:0]    need;
    status_t              eval_status;
    logic [COUNT_W:0]     trial;
    logic                 trial_ge;
    logic                 draw_ok;
    logic [TICKET_W-1:0]  win_ticket;
    logic [PROC_W-1:0]    win_id;

    assign room = COUNT_W'(MAX_TICKETS) - issued_reg;
    assign need = NEED_W'(cnt_reg) * NEED_W'(num_reg);

    always_comb begin
        eval_status = ST_OK;
        unique case (op_reg)
            OP_ADD: begin
                if (num_reg >= PROC_W'(MAX_PROCESSES)) begin
                    eval_status = ST_PROC_FULL;
                end
            end
            OP_ALL: begin
                if (need > NEED_W'(room)) begin
                    eval_status = ST_TICKET_FULL;
                end
            end
            OP_ONE: begin
                // The id check takes precedence over the capacity check.
                priority if (pid_reg == '0 || pid_reg > num_reg) begin
                    eval_status = ST_BAD_ID;
                end else if (cnt_reg > room) begin
                    eval_status = ST_TICKET_FULL;
                end
            end
            OP_DRAW: begin
                if (issued_reg == '0) begin
                    eval_status = ST_NO_TICKETS;
                end
            end
            default: begin
                eval_status = ST_OK;
            end
        endcase
    end

    // One restoring step of the remainder of rnd modulo issued.
    assign trial    = {rem_reg, rnd_reg[RAND_W-1]};
    assign trial_ge = (trial >= {1'b0, issued_reg});

    assign stat.op         = op_reg;
    assign stat.eval_ok    = (eval_status == ST_OK);
    assign stat.zero_work  = (op_reg == OP_ALL && (cnt_reg == '0 || num_reg == '0))
                           || (op_reg == OP_ONE && cnt_reg == '0);
    assign stat.grant_last = (left_reg == COUNT_W'(1))
                           && (op_reg == OP_ONE
                               || (PROC_W'(owner_reg) + PROC_W'(1)) == num_reg);
    assign stat.div_last   = (bit_reg == '0);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign draw_ok    = (op_reg == OP_DRAW) && (status_reg == ST_OK);
    assign win_ticket = draw_ok ? rem_reg[TICKET_W-1:0] : '0;
    assign win_id     = draw_ok ? PROC_W'(owner_rd_reg) + PROC_W'(1) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.grant_step) begin
            ticket_owner_mem[issued_reg[TICKET_W-1:0]] <= owner_reg;
        end
        if (cmd.mem_read) begin
            owner_rd_reg <= ticket_owner_mem[rem_reg[TICKET_W-1:0]];
        end
    end

    // Control state: counters and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issued_reg   <= '0;
            num_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.eval && op_reg == OP_ADD && eval_status == ST_OK) begin
                num_reg <= num_reg + PROC_W'(1);
            end
            if (cmd.grant_step) begin
                issued_reg <= issued_reg + COUNT_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= op_t'(s_tuser);
            cnt_reg <= s_tdata[COUNT_W-1:0];
            pid_reg <= s_tdata[COUNT_W +: PROC_W];
            rnd_reg <= s_tdata[COUNT_W + PROC_W +: RAND_W];
        end
        if (cmd.eval) begin
            status_reg <= eval_status;
            owner_reg  <= (op_reg == OP_ALL) ? '0 : OWNER_W'(pid_reg - PROC_W'(1));
            left_reg   <= cnt_reg;
            rem_reg    <= '0;
            bit_reg    <= DIV_CNT_W'(RAND_W - 1);
        end
        if (cmd.grant_step) begin
            if (left_reg == COUNT_W'(1)) begin
                // Grant to all moves on to the next process with a fresh count.
                owner_reg <= owner_reg + OWNER_W'(1);
                left_reg  <= cnt_reg;
            end else begin
                left_reg <= left_reg - COUNT_W'(1);
            end
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? COUNT_W'(trial - {1'b0, issued_reg}) : trial[COUNT_W-1:0];
            rnd_reg <= {rnd_reg[RAND_W-2:0], 1'b0};
            bit_reg <= bit_reg - DIV_CNT_W'(1);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                            num_reg, issued_reg, win_id, win_ticket, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/lottery_scheduler_ticket_table_top.sv =====
// Lottery scheduler with a ticket-owner table: top level.
// Instantiates lst_ctrl and lst_dp; depends on lst_pkg and the assertion macros.
// Usage:
//   The slave channel takes one request at a time: s_tuser carries the operation
//   (add process, tickets to all, tickets to one id, draw) and s_tdata the ticket
//   count, process id and random value. Every request yields exactly one result
//   on the master channel with the status, winning ticket and id, tickets issued
//   and processes present after the request.
//   Sequencing: a request is accepted and evaluated; its result goes straight
//   to the done state to be registered if it is rejected, an add or an empty
//   grant. Grants write one owner table entry per cycle. A draw runs a
//   bit-serial 32-bit modulo, one quotient bit per cycle, then one registered
//   table read. A new request is accepted the cycle after the result is loaded.
//   Reset clears the ticket and process counts and the result valid flag; the
//   owner table needs no clearing since only written entries are ever drawn.
//   When the receiver stalls, the result holds in the output register and the
//   next request may still be accepted and processed; its result waits until
//   the output register is taken.
`timescale 1ns / 1ps
`include "lottery_scheduler_ticket_table_top_macros.svh"

module lottery_scheduler_ticket_table_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ticket_count [10:0], process_id [15:11], random_value [47:16]
    input  logic [lst_pkg::S_TDATA_W-1:0]  s_tdata,
    // op [1:0]
    input  logic [lst_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [2:0], winner_ticket [12:3], winner_id [17:13],
    // total_count [28:18], process_total [33:29], zero fill above
    output logic [lst_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lst_pkg::*;

    lst_cmd_t  cmd;
    lst_stat_t stat;

    lst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lst_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    localparam int WT_LO = STATUS_W;
    localparam int WI_LO = WT_LO + TICKET_W;
    localparam int TC_LO = WI_LO + PROC_W;
    localparam int PT_LO = TC_LO + COUNT_W;

    `LST_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "request accepted while the previous one is still in progress")
    `LST_ASSERT_NOW(a_ticket_cap, m_tvalid,
        m_tdata[TC_LO +: COUNT_W] <= COUNT_W'(MAX_TICKETS),
        "ticket count exceeds table capacity")
    `LST_ASSERT_NOW(a_proc_cap, m_tvalid,
        m_tdata[PT_LO +: PROC_W] <= PROC_W'(MAX_PROCESSES),
        "process count exceeds table capacity")
    `LST_ASSERT_NOW(a_winner_in_range, m_tvalid && m_tdata[WI_LO +: PROC_W] != '0,
        COUNT_W'(m_tdata[WT_LO +: TICKET_W]) < m_tdata[TC_LO +: COUNT_W]
            && m_tdata[WI_LO +: PROC_W] <= m_tdata[PT_LO +: PROC_W],
        "winner ticket or id outside the issued range")

endmodule
